FILE: sv/esc_pkg.sv
// Shared types and constants for the expression syntax checker.
// Holds the bracket stack command and status structs, character classes and reason codes.
// No dependencies.
package esc_pkg;

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_DIGIT = 2'd1;
    localparam logic [1:0] CLS_OPER  = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_ADJ_OPER = 2'd1;
    localparam logic [1:0] FAULT_SPLIT    = 2'd2;

    localparam logic [2:0] REASON_OK      = 3'd0;
    localparam logic [2:0] REASON_EMPTY   = 3'd1;
    localparam logic [2:0] REASON_BAD     = 3'd2;
    localparam logic [2:0] REASON_BRACKET = 3'd3;
    localparam logic [2:0] REASON_ADJ_OP  = 3'd4;
    localparam logic [2:0] REASON_SPLIT   = 3'd5;

    localparam logic KIND_ROUND  = 1'b0;
    localparam logic KIND_SQUARE = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic kind;
    } stk_cmd_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
        logic top_kind;
    } stk_stat_t;

endpackage

FILE: sv/esc_bracket_stack.sv
// Bracket kind stack: one bit per open bracket, top entry held in a register.
// The entry below the top is read ahead from the memory every cycle.
// Depends on esc_pkg.
module esc_bracket_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  esc_pkg::stk_cmd_t cmd,
    output esc_pkg::stk_stat_t stat
);
    import esc_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic          kinds_mem [STACK_DEPTH];
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic          top_reg;
    logic          top_next;
    logic          below_reg;
    logic [LW-1:0] rd_addr;

    always_comb begin
        if (cmd.clear) begin
            level_next = '0;
        end else if (cmd.push) begin
            level_next = level_reg + LW'(1);
        end else if (cmd.pop) begin
            level_next = level_reg - LW'(1);
        end else begin
            level_next = level_reg;
        end
        if (cmd.push) begin
            top_next = cmd.kind;
        end else if (cmd.pop) begin
            top_next = below_reg;
        end else begin
            top_next = top_reg;
        end
        rd_addr = level_next - LW'(2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg   <= top_next;
        below_reg <= kinds_mem[rd_addr[AW-1:0]];
        if (cmd.push) begin
            kinds_mem[level_reg[AW-1:0]] <= cmd.kind;
        end
    end

    assign stat.empty    = (level_reg == '0);
    assign stat.one      = (level_reg == LW'(1));
    assign stat.full     = (level_reg == LW'(STACK_DEPTH));
    assign stat.top_kind = top_reg;

endmodule

FILE: sv/expression_syntax_checker.sv
// Top level of the expression syntax checker: input register, character checks and verdict.
// Instantiates esc_bracket_stack; depends on esc_pkg.
//
// Channel   Ports                      Beat contents
// input     s_tvalid/s_tready/s_tdata  tdata[7:0] character, tlast ends the expression
// result    m_tvalid/m_tready/m_tdata  tdata[0] valid_res, tdata[3:1] reason
//
// One character is taken per cycle unless a tlast beat is held; a beat is checked from the
// input register, and its verdict is on the result side from the edge that ends that check.
// The bracket stack keeps its top in a register and reads the entry below ahead, so a
// push or pop can follow in every cycle. A waiting verdict stalls only a beat with tlast,
// and the beats behind it wait while it sits in the input register; other beats keep
// flowing. Reset is synchronous and needs no clearing pass.
module expression_syntax_checker #(
    parameter int STACK_DEPTH = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [3:1] reason, [7:4] zero
);
    import esc_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       proc;

    logic [1:0] prev_class_reg, prev_class_next;
    logic       space_reg, space_next;
    logic       seen_reg, seen_next;
    logic       bad_reg, bad_next;
    logic       berr_reg, berr_next;
    logic [1:0] fault_reg, fault_next;

    logic       m_tvalid_reg;
    logic [2:0] reason_reg;
    logic [2:0] reason_next;

    logic       is_space, is_bad, is_open, is_close, is_valid;
    logic [1:0] cls;
    logic       want_kind;
    logic       nonempty_after;

    stk_cmd_t   cmd;
    stk_stat_t  stat;

    esc_bracket_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign proc     = in_valid_reg && (!last_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    always_comb begin
        is_space  = 1'b0;
        is_bad    = 1'b0;
        is_open   = 1'b0;
        is_close  = 1'b0;
        cls       = CLS_OTHER;
        want_kind = KIND_ROUND;
        unique case (char_reg) inside
            CH_NUL:                cls = CLS_NONE;
            CH_SPACE:              is_space = 1'b1;
            [CH_ZERO:CH_NINE]:     cls = CLS_DIGIT;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_HASH: cls = CLS_OPER;
            CH_DOT, CH_LF:         cls = CLS_OTHER;
            CH_LPAREN:             is_open = 1'b1;
            CH_LBRACK: begin
                is_open   = 1'b1;
                want_kind = KIND_SQUARE;
            end
            CH_RPAREN:             is_close = 1'b1;
            CH_RBRACK: begin
                is_close  = 1'b1;
                want_kind = KIND_SQUARE;
            end
            default:               is_bad = 1'b1;
        endcase
        is_valid = (char_reg != CH_NUL) && !is_space && !is_bad;
    end

    always_comb begin
        cmd.push  = 1'b0;
        cmd.pop   = 1'b0;
        cmd.clear = proc && last_reg;
        cmd.kind  = want_kind;
        berr_next = berr_reg;
        if (proc && is_valid && !berr_reg) begin
            if (is_open) begin
                if (stat.full) begin
                    berr_next = 1'b1;
                end else begin
                    cmd.push = 1'b1;
                end
            end else if (is_close) begin
                if (stat.empty) begin
                    berr_next = 1'b1;
                end else begin
                    cmd.pop = 1'b1;
                    if (stat.top_kind != want_kind) begin
                        berr_next = 1'b1;
                    end
                end
            end
        end

        if (cmd.push) begin
            nonempty_after = 1'b1;
        end else if (cmd.pop) begin
            nonempty_after = !stat.one;
        end else begin
            nonempty_after = !stat.empty;
        end

        seen_next       = seen_reg || (char_reg != CH_NUL);
        bad_next        = bad_reg || is_bad;
        fault_next      = fault_reg;
        prev_class_next = prev_class_reg;
        space_next      = space_reg;
        if (is_space) begin
            space_next = 1'b1;
        end else if (is_valid) begin
            if (fault_reg == FAULT_NONE) begin
                if (prev_class_reg == CLS_OPER && cls == CLS_OPER) begin
                    fault_next = FAULT_ADJ_OPER;
                end else if (prev_class_reg == CLS_DIGIT && cls == CLS_DIGIT && space_reg) begin
                    fault_next = FAULT_SPLIT;
                end
            end
            prev_class_next = cls;
            space_next      = 1'b0;
        end

        if (!seen_next) begin
            reason_next = REASON_EMPTY;
        end else if (bad_next) begin
            reason_next = REASON_BAD;
        end else if (berr_next || nonempty_after) begin
            reason_next = REASON_BRACKET;
        end else if (fault_next == FAULT_ADJ_OPER) begin
            reason_next = REASON_ADJ_OP;
        end else if (fault_next == FAULT_SPLIT) begin
            reason_next = REASON_SPLIT;
        end else begin
            reason_next = REASON_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_class_reg <= CLS_NONE;
            space_reg      <= 1'b0;
            seen_reg       <= 1'b0;
            bad_reg        <= 1'b0;
            berr_reg       <= 1'b0;
            fault_reg      <= FAULT_NONE;
        end else if (proc) begin
            if (last_reg) begin
                prev_class_reg <= CLS_NONE;
                space_reg      <= 1'b0;
                seen_reg       <= 1'b0;
                bad_reg        <= 1'b0;
                berr_reg       <= 1'b0;
                fault_reg      <= FAULT_NONE;
            end else begin
                prev_class_reg <= prev_class_next;
                space_reg      <= space_next;
                seen_reg       <= seen_next;
                bad_reg        <= bad_next;
                berr_reg       <= berr_next;
                fault_reg      <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (proc && last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && last_reg) begin
            reason_reg <= reason_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, reason_reg, (reason_reg == REASON_OK)};

endmodule
